// ===== sv/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the breath sensing candle flicker
// Widths, register indexes, profile codes and the status bundles exchanged
// between the breeze machine, the flicker unit and the top level.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  localparam int THR_W      = 10;
  localparam int ALPHA_W    = 16;
  localparam int PWM_W      = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_CHANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOWOUT_CHANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CALM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BREEZE   = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]   MIN_CHANGE_RST     = 10'd2;
  localparam logic [THR_W-1:0]   STRONG_CHANGE_RST  = 10'd4;
  localparam logic [THR_W-1:0]   BLOWOUT_CHANGE_RST = 10'd6;
  localparam logic [ALPHA_W-1:0] ALPHA_CALM_RST     = 16'd65327;
  localparam logic [ALPHA_W-1:0] ALPHA_BREEZE_RST   = 16'd109;

  // breeze mode codes as reported on the result channel
  localparam logic [MODE_W-1:0] MODE_CODE_CALM   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_ONSET  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_LIGHT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_HOLD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_FADING = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_STRONG = 3'd5;

  // LED profile codes
  typedef logic [1:0] profile_t;
  localparam profile_t PROF_CALM    = 2'd0;
  localparam profile_t PROF_LIGHT   = 2'd1;
  localparam profile_t PROF_STRONG  = 2'd2;
  localparam profile_t PROF_INITIAL = 2'd3;

  // noise generator
  localparam logic [31:0] LCG_MULT  = 32'd1103515245;
  localparam logic [31:0] LCG_INC   = 32'd12345;
  localparam logic [31:0] LCG_SEED  = 32'd1;
  localparam logic [15:0] NOISE_MID = 16'd16384;

  typedef struct packed {
    logic [THR_W-1:0] min_change;
    logic [THR_W-1:0] strong_change;
    logic [THR_W-1:0] blowout_change;
  } thr_t;

  typedef struct packed {
    logic              blown_out;
    profile_t          profile;
    logic [MODE_W-1:0] mode;
  } mode_stat_t;

  function automatic logic [7:0] prof_scale(profile_t p);
    logic [7:0] s;
    case (p)
      PROF_CALM:   s = 8'd50;
      PROF_LIGHT:  s = 8'd50;
      PROF_STRONG: s = 8'd200;
      default:     s = 8'd200;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] prof_gain(profile_t p);
    logic [7:0] g;
    case (p)
      PROF_STRONG: g = 8'd255;
      default:     g = 8'd200;
    endcase
    return g;
  endfunction

  function automatic logic [6:0] prof_offset(profile_t p);
    logic [6:0] o;
    case (p)
      PROF_CALM:   o = 7'd32;
      PROF_LIGHT:  o = 7'd64;
      PROF_STRONG: o = 7'd0;
      default:     o = 7'd32;
    endcase
    return o;
  endfunction

endpackage

// ===== sv/bsc_if.sv =====
// ----------------------------------------------------------------------------
// bsc_if: channel interfaces of the candle flicker core
// Input item channel, result channel and register write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface bsc_in_if import bsc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface bsc_out_if import bsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PWM_W-1:0]  pwm_level;
  logic [MODE_W-1:0] mode;
  logic              blown_out;

  modport source (output valid, output pwm_level, output mode, output blown_out,
                  input ready);
  modport sink   (input valid, input pwm_level, input mode, input blown_out,
                  output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/breath_sensing_candle_flicker_core.sv =====
// ----------------------------------------------------------------------------
// breath_sensing_candle_flicker_core: breath sensing candle flicker
// Breeze mode machine on sensor samples, noise driven LED flicker on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one word per item: operation 0 is a sensor sample, 1 is a
//          flicker tick. Every accepted word yields exactly one result word
//          on out_ch: pwm_level, mode and blown_out.
//   cfg_ch writes thresholds and filter coefficients; ready is always high.
//          Write only while the core is idle.
//   Flow: a sample, or any word once blown out, passes from acceptance
//   straight to the done state. A tick runs the bit-serial LCG multiply,
//   a setup step, the alpha multiply of the filter and the scale and gain
//   multiplies, and then its result is loaded from the done state.
//   One item is in work at a time; in_ch.ready rises again once its result
//   sits in the output register, so the next word can enter while the
//   previous result still waits on a stalled receiver.
//   If the receiver stalls, the finished result is held in the control
//   state until the output register frees up; nothing is dropped.
//   Reset (rst_n low at a clock edge) restores calm mode, the initial
//   profile, the noise seed and all register defaults, and empties out_ch.
// ----------------------------------------------------------------------------
module breath_sensing_candle_flicker_core import bsc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsc_in_if.sink    in_ch,
  bsc_out_if.source out_ch,
  bsc_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } ctl_state_t;

  ctl_state_t        st_r, st_nxt;

  // configuration registers
  thr_t              thr_r;
  logic [ALPHA_W-1:0] alpha_calm_r, alpha_breeze_r;

  // output register
  logic              out_valid_r;
  logic [PWM_W-1:0]  out_pwm_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              out_blown_r;

  logic              in_accept;
  logic              mode_step;
  logic              fl_start;
  logic              fl_done;
  logic [PWM_W-1:0]  pwm_hold;
  mode_stat_t        stat;
  logic              out_load;

  // accept only when no item is in work
  assign in_ch.ready = (st_r == C_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // once blown out, words pass straight to the result without touching state
  assign mode_step = in_accept && !stat.blown_out && !in_ch.operation;
  assign fl_start  = in_accept && !stat.blown_out && in_ch.operation;

  // load the result when the output register is empty or being drained
  assign out_load = (st_r == C_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      C_IDLE: begin
        if (fl_start) st_nxt = C_RUN;
        else if (in_accept) st_nxt = C_DONE;
      end
      C_RUN: begin
        if (fl_done) st_nxt = C_DONE;
      end
      C_DONE: begin
        if (out_load) st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload: LED forced dark once blown out
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pwm_r   <= stat.blown_out ? '0 : pwm_hold;
      out_mode_r  <= stat.mode;
      out_blown_r <= stat.blown_out;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pwm_level = out_pwm_r;
  assign out_ch.mode      = out_mode_r;
  assign out_ch.blown_out = out_blown_r;

  // register writes; unknown indexes are dropped, upper data bits ignored
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.min_change     <= MIN_CHANGE_RST;
      thr_r.strong_change  <= STRONG_CHANGE_RST;
      thr_r.blowout_change <= BLOWOUT_CHANGE_RST;
      alpha_calm_r         <= ALPHA_CALM_RST;
      alpha_breeze_r       <= ALPHA_BREEZE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_MIN_CHANGE:     thr_r.min_change     <= cfg_ch.data[THR_W-1:0];
        REG_STRONG_CHANGE:  thr_r.strong_change  <= cfg_ch.data[THR_W-1:0];
        REG_BLOWOUT_CHANGE: thr_r.blowout_change <= cfg_ch.data[THR_W-1:0];
        REG_ALPHA_CALM:     alpha_calm_r         <= cfg_ch.data[ALPHA_W-1:0];
        REG_ALPHA_BREEZE:   alpha_breeze_r       <= cfg_ch.data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  bsc_mode #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mode (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (mode_step),
    .sample (in_ch.sample),
    .thr    (thr_r),
    .stat   (stat)
  );

  bsc_flicker u_flicker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (fl_start),
    .profile      (stat.profile),
    .alpha_calm   (alpha_calm_r),
    .alpha_breeze (alpha_breeze_r),
    .done         (fl_done),
    .pwm_level    (pwm_hold)
  );

endmodule

// ===== sv/bsc_mode.sv =====
// ----------------------------------------------------------------------------
// bsc_mode: six-mode breeze machine
// Tracks the newest sensor reading and the drop between readings, moves
// between the breeze modes and picks the LED profile; latches blow-out.
// ----------------------------------------------------------------------------
module bsc_mode import bsc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  thr_t                   thr,
  output mode_stat_t             stat
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int CW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS + 2 : THR_W + 2;

  typedef enum logic [5:0] {
    M_CALM    = 6'b000001,
    M_ONSET   = 6'b000010,
    M_LIGHT   = 6'b000100,
    M_HOLD    = 6'b001000,
    M_FADING  = 6'b010000,
    M_STRONG  = 6'b100000
  } mode_fsm_t;

  mode_fsm_t              mode_r, mode_nxt;
  logic [SAMPLE_BITS-1:0] newest_r, newest_nxt;
  logic [DW-1:0]          drop_r, drop_nxt;
  profile_t               prof_r, prof_nxt;
  logic                   blown_r, blown_nxt;

  logic [DW-1:0]          fresh;
  logic [DW-1:0]          drop_use;
  logic                   use_fresh;
  logic                   ge_min, ge_strong, ge_blow;
  logic [MODE_W-1:0]      mode_code;

  function automatic logic drop_ge(logic [DW-1:0] d, logic [THR_W-1:0] t);
    logic signed [CW-1:0] ds;
    logic signed [CW-1:0] ts;
    ds = $signed({{(CW-DW){d[DW-1]}}, d});
    ts = $signed({{(CW-THR_W){1'b0}}, t});
    return ds >= ts;
  endfunction

  assign fresh     = {1'b0, newest_r} - {1'b0, sample};
  assign use_fresh = (mode_r == M_CALM) || (mode_r == M_LIGHT) || (mode_r == M_STRONG);
  assign drop_use  = use_fresh ? fresh : drop_r;
  assign ge_min    = drop_ge(drop_use, thr.min_change);
  assign ge_strong = drop_ge(drop_use, thr.strong_change);
  assign ge_blow   = drop_ge(drop_use, thr.blowout_change);

  always_comb begin
    mode_nxt   = mode_r;
    newest_nxt = newest_r;
    drop_nxt   = drop_r;
    prof_nxt   = prof_r;
    blown_nxt  = blown_r;
    if (step) begin
      newest_nxt = sample;
      drop_nxt   = drop_use;
      case (mode_r)
        M_CALM: begin
          if (ge_min) mode_nxt = M_ONSET;
        end
        M_ONSET, M_LIGHT: begin
          if (ge_strong) begin
            mode_nxt  = M_STRONG;
            prof_nxt  = PROF_STRONG;
            blown_nxt = blown_r | ge_blow;
          end else if (mode_r == M_ONSET) begin
            mode_nxt = M_LIGHT;
            prof_nxt = PROF_LIGHT;
          end else begin
            mode_nxt = M_HOLD;
          end
        end
        M_HOLD: begin
          if (ge_min) begin
            mode_nxt = M_LIGHT;
          end else begin
            mode_nxt = M_CALM;
            prof_nxt = PROF_CALM;
          end
        end
        M_FADING: begin
          if (ge_min) begin
            mode_nxt = M_LIGHT;
            prof_nxt = PROF_LIGHT;
          end else begin
            mode_nxt = M_CALM;
            prof_nxt = PROF_CALM;
          end
        end
        M_STRONG: begin
          if (!ge_strong) mode_nxt = M_FADING;
          blown_nxt = blown_r | ge_blow;
        end
        default: begin
          // no defined mode: leave everything untouched
          newest_nxt = newest_r;
          drop_nxt   = drop_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_CALM;
      newest_r <= '0;
      drop_r   <= '0;
      prof_r   <= PROF_INITIAL;
      blown_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      newest_r <= newest_nxt;
      drop_r   <= drop_nxt;
      prof_r   <= prof_nxt;
      blown_r  <= blown_nxt;
    end
  end

  always_comb begin
    case (mode_r)
      M_CALM:   mode_code = MODE_CODE_CALM;
      M_ONSET:  mode_code = MODE_CODE_ONSET;
      M_LIGHT:  mode_code = MODE_CODE_LIGHT;
      M_HOLD:   mode_code = MODE_CODE_HOLD;
      M_FADING: mode_code = MODE_CODE_FADING;
      M_STRONG: mode_code = MODE_CODE_STRONG;
      default:  mode_code = MODE_CODE_CALM;
    endcase
  end

  assign stat.blown_out = blown_r;
  assign stat.profile   = prof_r;
  assign stat.mode      = mode_code;

endmodule

// ===== sv/bsc_flicker.sv =====
// ----------------------------------------------------------------------------
// bsc_flicker: bit-serial noise, filter and PWM unit
// Advances the LCG, runs the one-pole low-pass filter and forms the
// saturated PWM level with shift-and-add multiplies, one bit per cycle.
// ----------------------------------------------------------------------------
module bsc_flicker import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  profile_t           profile,
  input  logic [ALPHA_W-1:0] alpha_calm,
  input  logic [ALPHA_W-1:0] alpha_breeze,
  output logic               done,
  output logic [PWM_W-1:0]   pwm_level
);

  localparam int ACC_W     = 35;
  localparam int MC_W      = 33;
  localparam int LCG_STEPS = 32;
  localparam int FLT_STEPS = ALPHA_W;
  localparam int LVL_STEPS = 8;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_LCG  = 5'b00010,
    F_PREP = 5'b00100,
    F_FILT = 5'b01000,
    F_LVL  = 5'b10000
  } fl_state_t;

  fl_state_t          st_r, st_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [31:0]        lcg_r, lcg_nxt;
  logic [15:0]        z_r, z_nxt;
  logic [15:0]        n_r, n_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [MC_W-1:0]    mc_r, mc_nxt;
  logic [MC_W-1:0]    nsh_r, nsh_nxt;
  logic [ALPHA_W-1:0] a_r, a_nxt;
  logic [7:0]         scale_r, scale_nxt;
  logic [7:0]         gain_r, gain_nxt;
  logic [PWM_W-1:0]   pwm_r, pwm_nxt;

  logic [31:0]        lcg_sum;
  logic [15:0]        n_c;
  logic [16:0]        d_c;
  logic [ACC_W-1:0]   mc_ext, nsh_ext;
  logic [ACC_W-1:0]   filt_sum, lvl_sum;
  logic [15:0]        z_new;
  logic [ALPHA_W-1:0] alpha_sel;

  assign lcg_sum  = acc_r[31:0] + mc_r[31:0];
  assign n_c      = {1'b0, lcg_r[30:16]} - NOISE_MID;
  assign d_c      = {z_r[15], z_r} - {n_c[15], n_c};
  assign mc_ext   = {{(ACC_W-MC_W){mc_r[MC_W-1]}}, mc_r};
  assign nsh_ext  = {{(ACC_W-MC_W){nsh_r[MC_W-1]}}, nsh_r};
  assign filt_sum = acc_r + (a_r[0] ? mc_ext : '0);
  assign lvl_sum  = acc_r + (scale_r[0] ? mc_ext : '0) + (gain_r[0] ? nsh_ext : '0);
  assign z_new    = filt_sum[31:16];

  always_comb begin
    case (profile)
      PROF_CALM:   alpha_sel = alpha_calm;
      PROF_LIGHT:  alpha_sel = alpha_breeze;
      PROF_STRONG: alpha_sel = alpha_breeze;
      default:     alpha_sel = '0;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    lcg_nxt   = lcg_r;
    z_nxt     = z_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    nsh_nxt   = nsh_r;
    a_nxt     = a_r;
    scale_nxt = scale_r;
    gain_nxt  = gain_r;
    pwm_nxt   = pwm_r;
    done      = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (start) begin
          acc_nxt = {{(ACC_W-32){1'b0}}, LCG_INC};
          mc_nxt  = {1'b0, lcg_r};
          cnt_nxt = '0;
          st_nxt  = F_LCG;
        end
      end
      F_LCG: begin
        // add the shifted state for each set bit of the multiplier
        if (LCG_MULT[cnt_r]) acc_nxt = {{(ACC_W-32){1'b0}}, lcg_sum};
        mc_nxt  = {mc_r[MC_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LCG_STEPS-1)) begin
          lcg_nxt = LCG_MULT[cnt_r] ? lcg_sum : acc_r[31:0];
          st_nxt  = F_PREP;
        end
      end
      F_PREP: begin
        // t = alpha*(z-n) + n*65536, rounding bias folded into bit 15
        n_nxt   = n_c;
        mc_nxt  = {{(MC_W-17){d_c[16]}}, d_c};
        acc_nxt = {{(ACC_W-32){n_c[15]}}, n_c, 16'h8000};
        a_nxt   = alpha_sel;
        cnt_nxt = '0;
        st_nxt  = F_FILT;
      end
      F_FILT: begin
        acc_nxt = filt_sum;
        mc_nxt  = {mc_r[MC_W-2:0], 1'b0};
        a_nxt   = {1'b0, a_r[ALPHA_W-1:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(FLT_STEPS-1)) begin
          z_nxt     = z_new;
          mc_nxt    = {{(MC_W-16){z_new[15]}}, z_new};
          nsh_nxt   = {{(MC_W-16){n_r[15]}}, n_r};
          acc_nxt   = {{(ACC_W-22){1'b0}}, prof_offset(profile), 15'd0};
          scale_nxt = prof_scale(profile);
          gain_nxt  = prof_gain(profile);
          cnt_nxt   = '0;
          st_nxt    = F_LVL;
        end
      end
      F_LVL: begin
        acc_nxt   = lvl_sum;
        mc_nxt    = {mc_r[MC_W-2:0], 1'b0};
        nsh_nxt   = {nsh_r[MC_W-2:0], 1'b0};
        scale_nxt = {1'b0, scale_r[7:1]};
        gain_nxt  = {1'b0, gain_r[7:1]};
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == 5'(LVL_STEPS-1)) begin
          // clamp negative to zero, anything past 255 to full scale
          if (lvl_sum[ACC_W-1]) pwm_nxt = '0;
          else if (|lvl_sum[ACC_W-1:23]) pwm_nxt = '1;
          else pwm_nxt = lvl_sum[22:15];
          done   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cnt_r <= '0;
      lcg_r <= LCG_SEED;
      z_r   <= '0;
      pwm_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      lcg_r <= lcg_nxt;
      z_r   <= z_nxt;
      pwm_r <= pwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    acc_r   <= acc_nxt;
    mc_r    <= mc_nxt;
    nsh_r   <= nsh_nxt;
    a_r     <= a_nxt;
    scale_r <= scale_nxt;
    gain_r  <= gain_nxt;
  end

  assign pwm_level = pwm_r;

endmodule

// ===== tb/breath_sensing_candle_flicker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breath_sensing_candle_flicker_core_tb: self-checking bench for the core
// Sends sensor samples and flicker ticks through the core with random gaps on
// both sides. An in-bench model of the breeze machine, the noise generator and
// the low-pass filter predicts each result word, and every field of every
// returned word is compared in order. Thresholds and coefficients are swept
// across several settings between phases, and the run ends with a blowout.
// ----------------------------------------------------------------------------
module breath_sensing_candle_flicker_core_tb;
  import bsc_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int THR_MAX      = (1 << THR_W) - 1;
  localparam int TICK_MARK    = -1;     // marks a tick in the directed plan
  localparam int GAP_PCT      = 31;     // chance in a hundred of an idle cycle
  localparam int PHASE_WORDS  = 150;
  localparam int DRAIN_CYCLES = 100;    // outlasts the latency of a tick

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CALM, MODE_ONSET, MODE_LIGHT, MODE_HOLD, MODE_FADING, MODE_STRONG
  } breeze_mode_e;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] smp;
  } sensor_word_t;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm;
    logic [MODE_W-1:0] mode;
    logic              blown;
  } led_reading_t;

  logic clk = 1'b0;
  logic rst_n;

  bsc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  bsc_out_if out_ch ();
  bsc_cfg_if cfg_ch ();

  breath_sensing_candle_flicker_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Candle model: register copies and state
  // --------------------------------------------------------------------------
  int               min_thr, strong_thr, blow_thr;
  logic [15:0]      alpha_calm_r, alpha_breeze_r;
  breeze_mode_e     breeze;
  int               last_smp;
  int               drop_amt;     // signed drop between readings
  profile_t         led_prof;
  logic [31:0]      lcg;
  logic [15:0]      glow;         // filter output, signed Q0.15
  logic [PWM_W-1:0] duty;
  logic             candle_out;

  sensor_word_t word_backlog[$];  // words waiting for the driver
  led_reading_t led_due[$];       // predicted result words, oldest first
  led_reading_t want;

  logic       no_gaps    = 1'b0;  // both sides run flat out while set
  logic       hold_input = 1'b0;  // sender starts no new word while set
  logic [5:0] modes_seen = '0;
  int         words_fed  = 0;
  int         ticks_fed  = 0;
  int         results_in = 0;
  int         mismatches = 0;

  // Advance the model by one accepted word and queue its result word.
  task automatic advance_candle(input logic op, input logic [SAMPLE_BITS-1:0] smp);
    longint       scale, offset, gain, alpha, z, n, t, v;
    int           prior;
    logic         to_strong;
    led_reading_t r;
    to_strong = 1'b0;
    if (!candle_out) begin
      if (op == OP_SAMPLE) begin
        prior = last_smp;
        last_smp = smp;
        // only calm, light and strong take a fresh drop; the rest reuse it
        case (breeze)
          MODE_CALM, MODE_LIGHT, MODE_STRONG: drop_amt = prior - last_smp;
          default: ;
        endcase
        case (breeze)
          MODE_CALM: begin
            if (drop_amt >= min_thr) breeze = MODE_ONSET;
          end
          MODE_ONSET: begin
            if (drop_amt >= strong_thr) begin
              to_strong = 1'b1;
            end else begin
              breeze = MODE_LIGHT;
              led_prof = PROF_LIGHT;
            end
          end
          MODE_LIGHT: begin
            if (drop_amt >= strong_thr) to_strong = 1'b1;
            else breeze = MODE_HOLD;
          end
          MODE_HOLD: begin
            if (drop_amt >= min_thr) begin
              breeze = MODE_LIGHT;
            end else begin
              breeze = MODE_CALM;
              led_prof = PROF_CALM;
            end
          end
          MODE_FADING: begin
            if (drop_amt >= min_thr) begin
              breeze = MODE_LIGHT;
              led_prof = PROF_LIGHT;
            end else begin
              breeze = MODE_CALM;
              led_prof = PROF_CALM;
            end
          end
          MODE_STRONG: begin
            if (drop_amt < strong_thr) breeze = MODE_FADING;
            if (drop_amt >= blow_thr) candle_out = 1'b1;
          end
          default: ;
        endcase
        if (to_strong) begin
          breeze = MODE_STRONG;
          led_prof = PROF_STRONG;
          if (drop_amt >= blow_thr) candle_out = 1'b1;
        end
      end else begin
        case (led_prof)
          PROF_CALM: begin
            scale = 50;  offset = 32; gain = 200; alpha = alpha_calm_r;
          end
          PROF_LIGHT: begin
            scale = 50;  offset = 64; gain = 200; alpha = alpha_breeze_r;
          end
          PROF_STRONG: begin
            scale = 200; offset = 0;  gain = 255; alpha = alpha_breeze_r;
          end
          default: begin
            scale = 200; offset = 32; gain = 200; alpha = 0;
          end
        endcase
        lcg = lcg * LCG_MULT + LCG_INC;
        n = lcg[30:16];
        n = n - 16384;
        z = $signed(glow);
        // one-pole low-pass, rounded half up
        t = z * alpha + (65536 - alpha) * n;
        z = (t + 32768) >>> 16;
        glow = z[15:0];
        v = scale * z + gain * n + offset * 32768;
        if (v < 0) duty = '0;
        else if ((v >>> 15) > 255) duty = 8'd255;
        else duty = v[22:15];
        ticks_fed++;
      end
    end
    r.pwm   = candle_out ? '0 : duty;
    r.mode  = breeze;
    r.blown = candle_out;
    led_due.push_back(r);
    modes_seen[breeze] = 1'b1;
    words_fed++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next backlog word, hold it until taken
  // --------------------------------------------------------------------------
  sensor_word_t nxt_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) advance_candle(in_ch.operation, in_ch.sample);
      // free to move on once the current word is taken or none is shown
      if (!in_ch.valid || in_ch.ready) begin
        if (word_backlog.size() != 0 && !hold_input &&
            (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          nxt_word = word_backlog.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.operation <= nxt_word.op;
          in_ch.sample    <= nxt_word.smp;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take result words, compare against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_in++;
        if (led_due.size() == 0) begin
          $display("%0t ns: result word with nothing expected: pwm %0d mode %0d blown %0d",
                   $time, out_ch.pwm_level, out_ch.mode, out_ch.blown_out);
          mismatches++;
        end else begin
          want = led_due.pop_front();
          if (out_ch.pwm_level !== want.pwm) begin
            $display("%0t ns: pwm_level expected %0d, got %0d",
                     $time, want.pwm, out_ch.pwm_level);
            mismatches++;
          end
          if (out_ch.mode !== want.mode) begin
            $display("%0t ns: mode expected %0d, got %0d", $time, want.mode, out_ch.mode);
            mismatches++;
          end
          if (out_ch.blown_out !== want.blown) begin
            $display("%0t ns: blown_out expected %0d, got %0d",
                     $time, want.blown, out_ch.blown_out);
            mismatches++;
          end
        end
      end
      // stall at random, except in the flat-out stretch
      out_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Write one register; call only while the core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    // bits above the register width are dropped, stray indexes ignored
    case (idx)
      REG_MIN_CHANGE:     min_thr        = val[THR_W-1:0];
      REG_STRONG_CHANGE:  strong_thr     = val[THR_W-1:0];
      REG_BLOWOUT_CHANGE: blow_thr       = val[THR_W-1:0];
      REG_ALPHA_CALM:     alpha_calm_r   = val[ALPHA_W-1:0];
      REG_ALPHA_BREEZE:   alpha_breeze_r = val[ALPHA_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every word is sent and every result word is home.
  task automatic settle();
    do @(negedge clk); while (word_backlog.size() != 0 || in_ch.valid || led_due.size() != 0);
  endtask

  task automatic push_word(input logic op, input int smp);
    sensor_word_t w;
    w.op  = op;
    w.smp = smp[SAMPLE_BITS-1:0];
    word_backlog.push_back(w);
  endtask

  // Mostly a slowly falling reading, as a breath against the sensor gives,
  // with random jumps as noise. Ticks carry random junk in the sample field.
  task automatic queue_walk(input int count);
    int walk;
    int s;
    int step;
    walk = last_smp;
    repeat (count) begin
      if ($urandom_range(1) == 1) begin
        push_word(OP_TICK, $urandom_range(SAMPLE_MAX));
      end else begin
        if ($urandom_range(99) < 15) begin
          s = $urandom_range(SAMPLE_MAX);
        end else begin
          step = $urandom_range(15);
          s = walk + 6 - step;
          if (s < 0) s = 0;
          if (s > SAMPLE_MAX) s = SAMPLE_MAX;
        end
        // keep clear of the only drop that reaches a full-scale blowout level
        if (walk == SAMPLE_MAX && s == 0) s = 1;
        push_word(OP_SAMPLE, s);
        walk = s;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int plan [24];
    int lo, hi, fin_blow;
    // drive every input to a known level before the first edge
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_SAMPLE;
    in_ch.sample    = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    // model state after reset
    min_thr        = MIN_CHANGE_RST;
    strong_thr     = STRONG_CHANGE_RST;
    blow_thr       = BLOWOUT_CHANGE_RST;
    alpha_calm_r   = ALPHA_CALM_RST;
    alpha_breeze_r = ALPHA_BREEZE_RST;
    breeze         = MODE_CALM;
    last_smp       = 0;
    drop_amt       = 0;
    led_prof       = PROF_INITIAL;
    lcg            = LCG_SEED;
    glow           = '0;
    duty           = '0;
    candle_out     = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk at reset thresholds (2, 4, 6): ticks on the initial
    // profile, a first sample that rises from zero, then calm -> onset ->
    // light -> hold -> light -> strong -> fading -> light -> hold -> calm,
    // and calm -> onset -> strong, staying strong, fading -> calm.
    plan = '{TICK_MARK, TICK_MARK, 1023, 1020, TICK_MARK, 1019, TICK_MARK, 1016,
             1015, 1010, TICK_MARK, 1007, TICK_MARK, 1006, 1005, 1004, TICK_MARK,
             1000, 999, 994, 990, 989, 988, TICK_MARK};
    foreach (plan[i]) begin
      if (plan[i] == TICK_MARK) push_word(OP_TICK, 0);
      else push_word(OP_SAMPLE, plan[i]);
    end
    settle();

    // Random phases, each under its own register setting. Blowout stays at
    // full scale so the candle survives until the finale.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          lo = 2; hi = 4;
        end
        1: begin
          lo = 0; hi = 0;
        end
        2: begin
          lo = 3; hi = 6;
        end
        3: begin
          lo = THR_MAX; hi = THR_MAX;
        end
        default: begin
          lo = $urandom_range(10);
          hi = lo + $urandom_range(10);
        end
      endcase
      write_reg(REG_MIN_CHANGE, lo | ($urandom_range(63) << THR_W));
      write_reg(REG_STRONG_CHANGE, hi | ($urandom_range(63) << THR_W));
      write_reg(REG_BLOWOUT_CHANGE, THR_MAX | ($urandom_range(63) << THR_W));
      write_reg(REG_ALPHA_CALM, ph == 0 ? 65535 : ph == 1 ? 0 : $urandom_range(65535));
      write_reg(REG_ALPHA_BREEZE, ph == 0 ? 0 : ph == 1 ? 65535 : $urandom_range(65535));
      if (ph >= 3) write_reg(CFG_IDX_W'(REG_ALPHA_BREEZE + 1 + ph % 3), $urandom);
      no_gaps = (ph == 2);
      @(negedge clk);
      queue_walk(PHASE_WORDS);
      if (ph == 4) begin
        // hold the sender midway until every outstanding result is home
        while (word_backlog.size() > PHASE_WORDS / 2) @(negedge clk);
        hold_input = 1'b1;
        while (in_ch.valid || led_due.size() != 0) @(negedge clk);
        hold_input = 1'b0;
      end
      settle();
    end
    no_gaps = 1'b0;

    // Finale: low breeze thresholds, blowout at zero, full scale or between;
    // steer with full-swing readings until the candle goes out.
    write_reg(REG_MIN_CHANGE, 1);
    write_reg(REG_STRONG_CHANGE, 2);
    case ($urandom_range(2))
      0: fin_blow = 0;
      1: fin_blow = THR_MAX;
      default: fin_blow = $urandom_range(THR_MAX - 1, 3);
    endcase
    write_reg(REG_BLOWOUT_CHANGE, fin_blow);
    @(negedge clk);
    for (int k = 0; k < 60 && !candle_out; k++) begin
      if ($urandom_range(3) == 0) push_word(OP_TICK, 0);
      else push_word(OP_SAMPLE, last_smp >= 512 ? 0 : SAMPLE_MAX);
      settle();
    end
    // once out, the candle must stay dark whatever arrives
    repeat (12) push_word(1'($urandom_range(1)), $urandom_range(SAMPLE_MAX));
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (led_due.size() != 0) begin
      $display("%0t ns: %0d result words never arrived", $time, led_due.size());
      mismatches++;
    end
    $display("Sent %0d words (%0d ticks taken), checked %0d result words over 9 settings.",
             words_fed, ticks_fed, results_in);
    $display("Breeze modes reached (strong..calm) %b, blown out %0d, mismatches %0d.",
             modes_seen, candle_out, mismatches);
    if (mismatches == 0) begin
      $display("breath_sensing_candle_flicker_core test passed");
    end else begin
      $display("breath_sensing_candle_flicker_core test failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes a small fraction of this.
  initial begin
    #20_000_000;
    $display("breath_sensing_candle_flicker_core test failed");
    $finish;
  end

endmodule
